>>> rtl/assert_macros.svh
// assertion macros for the rtl files, included by hoed_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/hoed_pkg.sv
// shared types and constants of the heel-off event detector
package hoed_pkg;

  localparam int unsigned ModeW  = 2;
  localparam int unsigned LimitW = 10;
  localparam int unsigned HoldW  = 11;
  localparam int unsigned IdxW   = 2;

  localparam logic [LimitW-1:0] HoldLimitRst = LimitW'(100);
  localparam logic [HoldW-1:0]  HoldCntMax   = HoldW'(1024);

  typedef enum logic [ModeW-1:0] {
    MODE_FOOT_ANKLE = 2'd0,
    MODE_FOOT       = 2'd1,
    MODE_SHANK_ANY  = 2'd2,
    MODE_SHANK_RISE = 2'd3
  } mode_e;

  typedef enum logic [IdxW-1:0] {
    CFG_DETECT_MODE     = 2'd0,
    CFG_FOOT_THRESHOLD  = 2'd1,
    CFG_SHANK_THRESHOLD = 2'd2,
    CFG_HOLD_LIMIT      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SHANK_NONE  = 2'd0,
    SHANK_LEVEL = 2'd1,
    SHANK_RISE  = 2'd2
  } shank_mark_e;

  typedef struct packed {
    mode_e             mode;
    logic [LimitW-1:0] hold_limit;
  } ctrl_t;

endpackage

>>> rtl/heel_off_event_detector.sv
// top level of the heel-off event detector: config registers and request pipeline
//
// One request carries one sample of foot rate, shank rate and ankle angle and
// yields exactly one result, heel_off, which is 1 when the stored marks form a
// heel-off event under the selected detect mode. A request is taken into an
// input register, the decision is made by compare logic between that register
// and the result register, and one request can be accepted every cycle while
// in_stall_o is low. The detector state (previous
// samples, marks, hold counter) is updated when a request moves to the result
// register, so consecutive requests see each other's effects in order. The
// input register keeps accepting while a finished result waits on a stalled
// output; only when both registers are full does in_stall_o rise. Registers
// are written through cfg_we_i / cfg_idx_i / cfg_data_i and should only be
// changed while no request is in flight.
module heel_off_event_detector import hoed_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // config write port
  input  logic                                    cfg_we_i,
  input  logic [IdxW-1:0]                         cfg_idx_i,
  input  logic [((SAMPLE_BITS > LimitW) ? SAMPLE_BITS : LimitW)-1:0] cfg_data_i,
  // sample requests
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]           foot_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]           shank_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]           ankle_sample_i,
  // results
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic                                    heel_off_o
);

  // configuration registers
  ctrl_t                         ctrl_q;
  logic signed [SAMPLE_BITS-1:0] foot_thr_q, shank_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q.mode       <= MODE_FOOT_ANKLE;
      ctrl_q.hold_limit <= HoldLimitRst;
      foot_thr_q        <= '0;
      shank_thr_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DETECT_MODE:     ctrl_q.mode       <= mode_e'(cfg_data_i[ModeW-1:0]);
        CFG_FOOT_THRESHOLD:  foot_thr_q        <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_SHANK_THRESHOLD: shank_thr_q       <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_HOLD_LIMIT:      ctrl_q.hold_limit <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                          in_vld_q;
  logic signed [SAMPLE_BITS-1:0] foot_q, shank_q, ankle_q;
  // result register
  logic                          out_vld_q;
  logic                          heel_off_q;

  logic out_free, advance, in_take, hit;

  // result slot is free when empty or being drained this cycle
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      foot_q  <= foot_sample_i;
      shank_q <= shank_sample_i;
      ankle_q <= ankle_sample_i;
    end
    if (advance) begin
      heel_off_q <= hit;
    end
  end

  hoed_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .ctrl_i      (ctrl_q),
    .foot_thr_i  (foot_thr_q),
    .shank_thr_i (shank_thr_q),
    .foot_i      (foot_q),
    .shank_i     (shank_q),
    .ankle_i     (ankle_q),
    .hit_o       (hit)
  );

  assign out_valid_o = out_vld_q;
  assign heel_off_o  = heel_off_q;

endmodule

>>> rtl/hoed_core.sv
// detection state and per-sample decision logic
`include "assert_macros.svh"

module hoed_core import hoed_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  ctrl_t                         ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] foot_thr_i,
  input  logic signed [SAMPLE_BITS-1:0] shank_thr_i,
  input  logic signed [SAMPLE_BITS-1:0] foot_i,
  input  logic signed [SAMPLE_BITS-1:0] shank_i,
  input  logic signed [SAMPLE_BITS-1:0] ankle_i,
  output logic                          hit_o
);

  localparam int unsigned DiffW = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] prev_foot_q, prev_shank_q, prev_ankle_q;
  logic signed [DiffW-1:0]       prev_adiff_q, adiff_d;
  logic                          foot_mark_q, foot_mark_d;
  logic                          ankle_mark_q, ankle_mark_d;
  shank_mark_e                   shank_mark_q, shank_mark_d;
  logic [HoldW-1:0]              hold_cnt_q, hold_cnt_d;

  logic foot_cross, ankle_turn, shank_level, shank_rise, expire, hit;
  logic foot_kept, ankle_kept;
  shank_mark_e shank_kept;

  assign adiff_d = DiffW'({ankle_i[SAMPLE_BITS-1], ankle_i})
                 - DiffW'({prev_ankle_q[SAMPLE_BITS-1], prev_ankle_q});

  assign foot_cross  = (foot_i < prev_foot_q) && (foot_i <= foot_thr_i)
                     && (prev_foot_q > foot_thr_i);
  assign ankle_turn  = !prev_adiff_q[DiffW-1] && (ankle_i < prev_ankle_q);
  assign shank_level = (shank_i >= shank_thr_i);
  assign shank_rise  = (shank_i > prev_shank_q) && shank_level
                     && (prev_shank_q < shank_thr_i);

  // expired partial pattern is dropped before anything else
  assign expire     = hold_cnt_q > {1'b0, ctrl_i.hold_limit};
  assign foot_kept  = foot_mark_q && !expire;
  assign ankle_kept = ankle_mark_q && !expire;
  assign shank_kept = expire ? SHANK_NONE : shank_mark_q;

  always_comb begin
    hold_cnt_d   = expire ? '0 : hold_cnt_q;
    if (foot_kept || ankle_kept) begin
      hold_cnt_d = hold_cnt_d + HoldW'(1);
    end
    foot_mark_d  = foot_kept || foot_cross;
    ankle_mark_d = ankle_kept || ankle_turn;
    // a rise outranks the level mark, the level mark overwrites an old rise
    if (shank_rise) begin
      shank_mark_d = SHANK_RISE;
    end else if (shank_level) begin
      shank_mark_d = SHANK_LEVEL;
    end else begin
      shank_mark_d = shank_kept;
    end

    case (ctrl_i.mode)
      MODE_FOOT_ANKLE: hit = foot_mark_d && ankle_mark_d;
      MODE_FOOT:       hit = foot_mark_d;
      MODE_SHANK_ANY:  hit = (shank_mark_d == SHANK_LEVEL) || (shank_mark_d == SHANK_RISE);
      default:         hit = (shank_mark_d == SHANK_RISE);
    endcase

    if (hit) begin
      foot_mark_d  = 1'b0;
      ankle_mark_d = 1'b0;
      shank_mark_d = SHANK_NONE;
      hold_cnt_d   = '0;
    end
  end

  assign hit_o = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_foot_q  <= '0;
      prev_shank_q <= '0;
      prev_ankle_q <= '0;
      prev_adiff_q <= '0;
      foot_mark_q  <= 1'b0;
      ankle_mark_q <= 1'b0;
      shank_mark_q <= SHANK_NONE;
      hold_cnt_q   <= '0;
    end else if (step_i) begin
      prev_foot_q  <= foot_i;
      prev_shank_q <= shank_i;
      prev_ankle_q <= ankle_i;
      prev_adiff_q <= adiff_d;
      foot_mark_q  <= foot_mark_d;
      ankle_mark_q <= ankle_mark_d;
      shank_mark_q <= shank_mark_d;
      hold_cnt_q   <= hold_cnt_d;
    end
  end

  `ASSERT_IMPL(a_hold_bound, clk_i, rst_ni, 1'b1, hold_cnt_q <= HoldCntMax)
  `ASSERT_NEXT(a_hit_clears, clk_i, rst_ni, step_i && hit, !foot_mark_q && !ankle_mark_q && (shank_mark_q == SHANK_NONE) && (hold_cnt_q == '0))
  `ASSERT_NEXT(a_idle_holds, clk_i, rst_ni, !step_i, $stable(prev_adiff_q) && $stable(hold_cnt_q) && $stable(prev_foot_q))

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// testbench of the heel-off event detector: scoreboard, sample drivers and result checks
module tb import hoed_pkg::*; ();

  localparam int unsigned SampleBits = 16;
  localparam int unsigned CfgW = (SampleBits > LimitW) ? SampleBits : LimitW;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [SampleBits:0]   slope_t;

  // ---------------------------------------------------------------------------
  // gait scoreboard: tracks the detector state, predicts heel_off per request
  // ---------------------------------------------------------------------------
  class heel_off_scoreboard;
    // register copies
    mode_e             mode;
    sample_t           foot_thr;
    sample_t           shank_thr;
    logic [LimitW-1:0] hold_limit;
    // detector state
    sample_t           last_foot;
    sample_t           last_shank;
    sample_t           last_ankle;
    slope_t            last_ankle_slope;
    bit                foot_mark;
    bit                ankle_mark;
    shank_mark_e       shank_mark;
    logic [HoldW-1:0]  hold_count;
    // predicted heel_off values, oldest first
    bit                expected_heel_off[$];
    int unsigned       mismatches;

    function new();
      mode             = MODE_FOOT_ANKLE;
      foot_thr         = '0;
      shank_thr        = '0;
      hold_limit       = HoldLimitRst;
      last_foot        = '0;
      last_shank       = '0;
      last_ankle       = '0;
      last_ankle_slope = '0;
      mismatches       = 0;
      clear_marks();
    endfunction

    function void clear_marks();
      foot_mark  = 1'b0;
      ankle_mark = 1'b0;
      shank_mark = SHANK_NONE;
      hold_count = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        CFG_DETECT_MODE:     mode = mode_e'(data[ModeW-1:0]);
        CFG_FOOT_THRESHOLD:  foot_thr = data[SampleBits-1:0];
        CFG_SHANK_THRESHOLD: shank_thr = data[SampleBits-1:0];
        CFG_HOLD_LIMIT:      hold_limit = data[LimitW-1:0];
        default: ;
      endcase
    endfunction

    // one accepted request: advance the state and queue the expected result
    function void note_sample(sample_t foot, sample_t shank, sample_t ankle);
      slope_t foot_slope;
      slope_t shank_slope;
      slope_t ankle_slope;
      bit     foot_cross;
      bit     ankle_turn;
      bit     shank_level;
      bit     shank_rise;
      bit     hit;
      // 17-bit differences, no wrap
      foot_slope  = foot - last_foot;
      shank_slope = shank - last_shank;
      ankle_slope = ankle - last_ankle;
      foot_cross  = foot_slope < 0 && foot <= foot_thr && last_foot > foot_thr;
      ankle_turn  = last_ankle_slope >= 0 && ankle_slope < 0;
      shank_level = shank >= shank_thr;
      shank_rise  = shank_slope > 0 && shank >= shank_thr && last_shank < shank_thr;

      // a pattern held too long is dropped before anything else
      if (hold_count > hold_limit) clear_marks();
      // only the foot and ankle marks keep the counter running
      if (foot_mark || ankle_mark) hold_count = hold_count + 1'b1;

      if (foot_cross) foot_mark = 1'b1;
      if (ankle_turn) ankle_mark = 1'b1;
      if (shank_level) shank_mark = SHANK_LEVEL;
      // a rise beats a plain level on the same tick
      if (shank_rise) shank_mark = SHANK_RISE;

      case (mode)
        MODE_FOOT_ANKLE: hit = foot_mark && ankle_mark;
        MODE_FOOT:       hit = foot_mark;
        MODE_SHANK_ANY:  hit = shank_mark != SHANK_NONE;
        default:         hit = shank_mark == SHANK_RISE;
      endcase
      if (hit) clear_marks();

      last_foot        = foot;
      last_shank       = shank;
      last_ankle       = ankle;
      last_ankle_slope = ankle_slope;
      expected_heel_off.push_back(hit);
    endfunction

    function void check_heel_off(logic got);
      bit want;
      if (expected_heel_off.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: heel_off result %b with no request pending", $realtime, got);
      end else begin
        want = expected_heel_off.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: heel_off mismatch, expected %b actual %b", $realtime, want, got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_heel_off.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block under test
  // ---------------------------------------------------------------------------
  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [IdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic            in_valid_i;
  logic            in_stall_o;
  sample_t         foot_sample_i;
  sample_t         shank_sample_i;
  sample_t         ankle_sample_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic            heel_off_o;

  heel_off_event_detector #(
    .SAMPLE_BITS(SampleBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .foot_sample_i (foot_sample_i),
    .shank_sample_i(shank_sample_i),
    .ankle_sample_i(ankle_sample_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .heel_off_o    (heel_off_o)
  );

  heel_off_scoreboard gait_sb = new();

  // when set, neither side inserts gaps or stalls
  bit no_idle = 1'b0;
  int stall_left = 0;

  // 100 MHz clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // gap length: mostly short, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic sample_t sat16(int v);
    if (v > 32767) return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  function automatic sample_t pick_threshold();
    case ($urandom_range(0, 4))
      0: return sample_t'(-32768);
      1: return sample_t'(32767);
      2: return '0;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [LimitW-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return LimitW'($urandom_range(1, 30));
      default: return LimitW'($urandom_range(0, 1023));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stall, checks at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      stall_left  = pick_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) gait_sb.check_heel_off(heel_off_o);
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // called just after a falling edge; returns just after the falling edge that
  // follows acceptance, with valid still high so a back-to-back request can
  // reuse it without a second assignment in the same step
  task automatic send_sample(sample_t foot, sample_t shank, sample_t ankle);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 2) == 0) gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    foot_sample_i  <= foot;
    shank_sample_i <= shank;
    ankle_sample_i <= ankle;
    do @(posedge clk_i); while (in_stall_o);
    gait_sb.note_sample(foot, shank, ankle);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    send_sample(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
  endtask

  // one stride: foot falls across its threshold, ankle rises then falls,
  // shank rises across its threshold, with some noise on top
  task automatic send_stride();
    int len;
    int mid;
    int k;
    int foot_step;
    int shank_step;
    int ankle_step;
    int ankle_base;
    int jitter;
    int fv;
    int sv;
    int av;
    len        = $urandom_range(4, 12);
    mid        = len / 2;
    foot_step  = $urandom_range(1, 6000);
    shank_step = $urandom_range(1, 6000);
    ankle_step = $urandom_range(1, 6000);
    ankle_base = int'($urandom_range(0, 65535)) - 32768;
    for (k = 0; k < len; k++) begin
      jitter = int'($urandom_range(0, 200)) - 100;
      fv = int'(gait_sb.foot_thr) + (mid - k) * foot_step + jitter;
      jitter = int'($urandom_range(0, 200)) - 100;
      sv = int'(gait_sb.shank_thr) + (k - mid) * shank_step + jitter;
      av = ankle_base + ((k < mid) ? k : 2 * mid - k) * ankle_step;
      // broken strides: one signal jumps somewhere else
      if ($urandom_range(0, 7) == 0) fv = int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 7) == 0) sv = int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 7) == 0) av = int'($urandom_range(0, 65535)) - 32768;
      send_sample(sat16(fv), sat16(sv), sat16(av));
    end
  endtask

  // drop valid and let every queued result come out before touching registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (gait_sb.pending() != 0);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    gait_sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic write_regs(mode_e m, sample_t foot_thr, sample_t shank_thr,
                            logic [LimitW-1:0] lim);
    write_reg(CFG_DETECT_MODE, CfgW'(m));
    write_reg(CFG_FOOT_THRESHOLD, CfgW'(foot_thr));
    write_reg(CFG_SHANK_THRESHOLD, CfgW'(shank_thr));
    write_reg(CFG_HOLD_LIMIT, CfgW'(lim));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int p;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_DETECT_MODE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    foot_sample_i  = '0;
    shank_sample_i = '0;
    ankle_sample_i = '0;
    out_stall_i    = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: foot and ankle mode, zero thresholds
    // first tick compares against zero history, ankle turns at once
    send_sample(-16'sd1, 16'sd0, -16'sd1);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    // full-scale fall: largest ankle swing, foot cross and ankle turn together
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh5555, 16'sh5555, 16'sh5555);
    send_sample(16'shaaaa, 16'shaaaa, 16'shaaaa);
    send_sample(16'sd0, 16'sd0, 16'sd0);

    // foot only, lowest foot threshold, zero hold limit
    wait_idle();
    write_regs(MODE_FOOT, 16'sh8000, 16'sh7fff, '0);
    send_sample(16'sd100, 16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh7fff, 16'sd0);
    send_sample(16'sh8000, 16'sh8000, 16'sd5);
    send_sample(16'sd0, 16'sd0, 16'sd0);

    // shank level or rise, highest shank threshold, longest hold
    wait_idle();
    write_regs(MODE_SHANK_ANY, 16'sd0, 16'sh7fff, '1);
    send_sample(16'sd0, 16'sh7ffe, 16'sd0);
    send_sample(16'sd0, 16'sh7fff, 16'sd0);
    send_sample(16'sd0, 16'sh7fff, 16'sd0);
    send_sample(16'sd0, 16'sh8000, 16'sd0);

    // shank rise only; level and rise on the same tick, then level alone
    wait_idle();
    write_regs(MODE_SHANK_RISE, 16'sd0, 16'sd0, 10'd3);
    send_sample(16'sd0, -16'sd5, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd7, 16'sd0);
    send_sample(16'sd0, 16'sd7, 16'sd0);
    send_sample(16'sd0, -16'sd3, 16'sd0);
    send_sample(16'sd3, 16'sd3, 16'sd0);

    // ankle mark held with no foot cross possible, then limit lowered under it
    wait_idle();
    write_regs(MODE_FOOT_ANKLE, 16'sh7fff, pick_threshold(), '1);
    repeat (30) send_random();
    wait_idle();
    write_regs(MODE_FOOT_ANKLE, 16'sh7fff, gait_sb.shank_thr, 10'd2);
    repeat (20) send_random();

    // long hold: the counter climbs past a mid-range limit and is cleared
    wait_idle();
    write_regs(MODE_FOOT_ANKLE, 16'sh7fff, 16'sd0, 10'd60);
    no_idle = 1'b1;
    repeat (70) send_random();
    wait_idle();
    no_idle = 1'b0;

    // random phases: mostly strides, some raw noise
    for (p = 0; p < 7; p++) begin
      wait_idle();
      write_regs(mode_e'($urandom_range(0, 3)), pick_threshold(), pick_threshold(),
                 pick_limit());
      no_idle = (p % 3 == 2);
      repeat (7) begin
        if ($urandom_range(0, 3) == 0) repeat (3) send_random();
        else send_stride();
      end
    end
    no_idle = 1'b0;

    // drain, then wait for stray results before the final check
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (gait_sb.mismatches == 0 && gait_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
